>>> src/button_multi_click_detector_macros.svh
// Assertion macros shared by the checker of the button gesture detector
`ifndef BUTTON_MULTI_CLICK_DETECTOR_MACROS_SVH
`define BUTTON_MULTI_CLICK_DETECTOR_MACROS_SVH

// Property must hold at every clock edge outside reset
`define BMCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define BMCD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> src/bmcd_pkg.sv
// Shared types, constants and gesture indexes of the button gesture detector
package bmcd_pkg;

  // Default ring depth per button
  localparam int RING_DEPTH_DEF = 4;

  // Reset values of the configuration registers
  localparam logic [15:0] GAP_MS_RST  = 16'd500;
  localparam logic [15:0] LONG_MS_RST = 16'd800;

  typedef logic [31:0] time_t;
  typedef logic [15:0] dur_t;
  typedef logic [15:0] gap_t;
  typedef logic [1:0]  btn_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_GAP_MS  = 1'b0,
    CFG_LONG_MS = 1'b1
  } cfg_idx_e;

  // Buttons
  localparam int   NBTN      = 3;
  localparam btn_t BTN_CHEST = 2'd0;
  localparam btn_t BTN_LEFT  = 2'd1;
  localparam btn_t BTN_RIGHT = 2'd2;

  // Gestures, one report latch each
  localparam int NGST             = 11;
  localparam int GST_CHEST_LONG   = 0;
  localparam int GST_CHEST_SINGLE = 1;
  localparam int GST_CHEST_DOUBLE = 2;
  localparam int GST_CHEST_TRIPLE = 3;
  localparam int GST_CHEST_QUAD   = 4;
  localparam int GST_LEFT_LONG    = 5;
  localparam int GST_LEFT_SINGLE  = 6;
  localparam int GST_LEFT_DOUBLE  = 7;
  localparam int GST_RIGHT_LONG   = 8;
  localparam int GST_RIGHT_SINGLE = 9;
  localparam int GST_RIGHT_DOUBLE = 10;

  // Button whose ring a gesture watches
  function automatic btn_t gst_button(input int g);
    btn_t b;
    if (g <= GST_CHEST_QUAD) begin
      b = BTN_CHEST;
    end else if (g <= GST_LEFT_DOUBLE) begin
      b = BTN_LEFT;
    end else begin
      b = BTN_RIGHT;
    end
    return b;
  endfunction

endpackage

>>> src/button_multi_click_detector.sv
// Top level of the multi-click button gesture detector
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  input    | in_valid_i / in_ready_o | time_ms_i, *_level_i, durations_valid_i,
//           |                         | *_duration_i
//  result   | out_valid_o/out_ready_i | chest/left/right gesture flags, save_images_o
//  config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i (always ready)
//
// One tick per clock while results are taken: an input register feeds the ring update
// and gesture checks, which load the result register.
// Reset clears counts, levels, report latches, save flag and restores the registers;
// ring contents need no clearing since entries beyond the count are never used.
// A stalled result holds in the output register; in_ready_o drops only while both
// the input register and the output register are full and the result is not taken.
module button_multi_click_detector #(
  parameter int RING_DEPTH = bmcd_pkg::RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input ticks
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] time_ms_i,
  input  logic        chest_level_i,
  input  logic        left_level_i,
  input  logic        right_level_i,
  input  logic        durations_valid_i,
  input  logic [15:0] chest_duration_i,
  input  logic [15:0] left_duration_i,
  input  logic [15:0] right_duration_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        chest_long_o,
  output logic        chest_single_o,
  output logic        chest_double_o,
  output logic        chest_triple_o,
  output logic        chest_quad_o,
  output logic        left_long_o,
  output logic        left_single_o,
  output logic        left_double_o,
  output logic        right_long_o,
  output logic        right_single_o,
  output logic        right_double_o,
  output logic        save_images_o
);

  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int NBTN  = bmcd_pkg::NBTN;
  localparam int NGST  = bmcd_pkg::NGST;

  typedef logic [CNT_W-1:0] cnt_t;

  // Configuration registers
  bmcd_pkg::gap_t  gap_q;
  bmcd_pkg::dur_t  long_q;

  // Input register
  logic              s1_valid_q;
  bmcd_pkg::time_t   s1_time_q;
  logic [NBTN-1:0]   s1_lvl_q;
  logic              s1_dv_q;
  bmcd_pkg::dur_t    s1_dur_q [NBTN];

  // Press rings, newest entry at index 0
  bmcd_pkg::time_t   ring_time_q [NBTN][RING_DEPTH];
  bmcd_pkg::time_t   ring_time_d [NBTN][RING_DEPTH];
  bmcd_pkg::dur_t    ring_dur_q  [NBTN][RING_DEPTH];
  bmcd_pkg::dur_t    ring_dur_d  [NBTN][RING_DEPTH];
  cnt_t              ring_cnt_q  [NBTN];
  cnt_t              ring_cnt_d  [NBTN];
  logic [NBTN-1:0]   prior_q;
  logic [NBTN-1:0]   push;

  // Report latches and save flag
  bmcd_pkg::time_t   latch_q [NGST];
  bmcd_pkg::time_t   latch_d [NGST];
  logic              save_q;
  logic              save_d;
  logic [NGST-1:0]   hit;

  // Result register
  logic              out_valid_q;
  logic [NGST-1:0]   res_q;
  logic              save_out_q;

  logic              in_xfer;
  logic              adv;
  logic              fire;

  // Long press: newest press not yet reported and longer than the limit
  function automatic logic long_ok(
    input bmcd_pkg::dur_t  d [RING_DEPTH],
    input bmcd_pkg::time_t t [RING_DEPTH],
    input cnt_t            cnt,
    input bmcd_pkg::time_t mark,
    input bmcd_pkg::dur_t  lim
  );
    return (cnt != '0) && (mark != t[0]) && (d[0] > lim);
  endfunction

  // Group of n clicks: settled, tight inside, isolated from the next older press in the ring
  function automatic logic click_ok(
    input bmcd_pkg::time_t t [RING_DEPTH],
    input bmcd_pkg::dur_t  d [RING_DEPTH],
    input cnt_t            cnt,
    input int              n,
    input bmcd_pkg::time_t mark,
    input bmcd_pkg::time_t now,
    input bmcd_pkg::gap_t  gap,
    input bmcd_pkg::dur_t  lim
  );
    logic            ok;
    bmcd_pkg::time_t gap_w;
    gap_w = bmcd_pkg::time_t'(gap);
    ok    = (cnt >= cnt_t'(n)) && (mark != t[0]) && ((now - t[0]) >= gap_w);
    for (int i = 0; i < RING_DEPTH - 1; i++) begin
      if (i < n - 1) begin
        if (((t[i] - t[i+1]) > gap_w) || (d[i] > lim)) begin
          ok = 1'b0;
        end
      end else if ((i == n - 1) && (cnt > cnt_t'(n))) begin
        if (((t[i] - t[i+1]) < gap_w) || (d[i] > lim)) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  // Handshake control
  assign adv         = !out_valid_q || out_ready_i;
  assign fire        = s1_valid_q && adv;
  assign in_ready_o  = !s1_valid_q || adv;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q  <= bmcd_pkg::GAP_MS_RST;
      long_q <= bmcd_pkg::LONG_MS_RST;
    end else if (cfg_valid_i) begin
      case (bmcd_pkg::cfg_idx_e'(cfg_index_i))
        bmcd_pkg::CFG_GAP_MS:  gap_q  <= cfg_data_i;
        bmcd_pkg::CFG_LONG_MS: long_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Capture the tick payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_time_q                     <= time_ms_i;
      s1_lvl_q[bmcd_pkg::BTN_CHEST] <= chest_level_i;
      s1_lvl_q[bmcd_pkg::BTN_LEFT]  <= left_level_i;
      s1_lvl_q[bmcd_pkg::BTN_RIGHT] <= right_level_i;
      s1_dv_q                       <= durations_valid_i;
      s1_dur_q[bmcd_pkg::BTN_CHEST] <= chest_duration_i;
      s1_dur_q[bmcd_pkg::BTN_LEFT]  <= left_duration_i;
      s1_dur_q[bmcd_pkg::BTN_RIGHT] <= right_duration_i;
    end
  end

  // Push a falling edge with valid durations into its ring, dropping the oldest entry when full
  always_comb begin
    ring_time_d = ring_time_q;
    ring_dur_d  = ring_dur_q;
    ring_cnt_d  = ring_cnt_q;
    for (int b = 0; b < NBTN; b++) begin
      push[b] = s1_dv_q && prior_q[b] && !s1_lvl_q[b];
      if (push[b]) begin
        ring_time_d[b][0] = s1_time_q;
        ring_dur_d[b][0]  = s1_dur_q[b];
        for (int i = 1; i < RING_DEPTH; i++) begin
          ring_time_d[b][i] = ring_time_q[b][i-1];
          ring_dur_d[b][i]  = ring_dur_q[b][i-1];
        end
        if (ring_cnt_q[b] != cnt_t'(RING_DEPTH)) begin
          ring_cnt_d[b] = ring_cnt_q[b] + 1'b1;
        end
      end
    end
  end

  // Evaluate every gesture on the updated rings
  always_comb begin
    hit[bmcd_pkg::GST_CHEST_LONG] = long_ok(ring_dur_d[bmcd_pkg::BTN_CHEST],
      ring_time_d[bmcd_pkg::BTN_CHEST], ring_cnt_d[bmcd_pkg::BTN_CHEST],
      latch_q[bmcd_pkg::GST_CHEST_LONG], long_q);
    hit[bmcd_pkg::GST_CHEST_SINGLE] = click_ok(ring_time_d[bmcd_pkg::BTN_CHEST],
      ring_dur_d[bmcd_pkg::BTN_CHEST], ring_cnt_d[bmcd_pkg::BTN_CHEST], 1,
      latch_q[bmcd_pkg::GST_CHEST_SINGLE], s1_time_q, gap_q, long_q);
    hit[bmcd_pkg::GST_CHEST_DOUBLE] = click_ok(ring_time_d[bmcd_pkg::BTN_CHEST],
      ring_dur_d[bmcd_pkg::BTN_CHEST], ring_cnt_d[bmcd_pkg::BTN_CHEST], 2,
      latch_q[bmcd_pkg::GST_CHEST_DOUBLE], s1_time_q, gap_q, long_q);
    hit[bmcd_pkg::GST_CHEST_TRIPLE] = click_ok(ring_time_d[bmcd_pkg::BTN_CHEST],
      ring_dur_d[bmcd_pkg::BTN_CHEST], ring_cnt_d[bmcd_pkg::BTN_CHEST], 3,
      latch_q[bmcd_pkg::GST_CHEST_TRIPLE], s1_time_q, gap_q, long_q);
    hit[bmcd_pkg::GST_CHEST_QUAD] = click_ok(ring_time_d[bmcd_pkg::BTN_CHEST],
      ring_dur_d[bmcd_pkg::BTN_CHEST], ring_cnt_d[bmcd_pkg::BTN_CHEST], 4,
      latch_q[bmcd_pkg::GST_CHEST_QUAD], s1_time_q, gap_q, long_q);
    hit[bmcd_pkg::GST_LEFT_LONG] = long_ok(ring_dur_d[bmcd_pkg::BTN_LEFT],
      ring_time_d[bmcd_pkg::BTN_LEFT], ring_cnt_d[bmcd_pkg::BTN_LEFT],
      latch_q[bmcd_pkg::GST_LEFT_LONG], long_q);
    hit[bmcd_pkg::GST_LEFT_SINGLE] = click_ok(ring_time_d[bmcd_pkg::BTN_LEFT],
      ring_dur_d[bmcd_pkg::BTN_LEFT], ring_cnt_d[bmcd_pkg::BTN_LEFT], 1,
      latch_q[bmcd_pkg::GST_LEFT_SINGLE], s1_time_q, gap_q, long_q);
    hit[bmcd_pkg::GST_LEFT_DOUBLE] = click_ok(ring_time_d[bmcd_pkg::BTN_LEFT],
      ring_dur_d[bmcd_pkg::BTN_LEFT], ring_cnt_d[bmcd_pkg::BTN_LEFT], 2,
      latch_q[bmcd_pkg::GST_LEFT_DOUBLE], s1_time_q, gap_q, long_q);
    hit[bmcd_pkg::GST_RIGHT_LONG] = long_ok(ring_dur_d[bmcd_pkg::BTN_RIGHT],
      ring_time_d[bmcd_pkg::BTN_RIGHT], ring_cnt_d[bmcd_pkg::BTN_RIGHT],
      latch_q[bmcd_pkg::GST_RIGHT_LONG], long_q);
    hit[bmcd_pkg::GST_RIGHT_SINGLE] = click_ok(ring_time_d[bmcd_pkg::BTN_RIGHT],
      ring_dur_d[bmcd_pkg::BTN_RIGHT], ring_cnt_d[bmcd_pkg::BTN_RIGHT], 1,
      latch_q[bmcd_pkg::GST_RIGHT_SINGLE], s1_time_q, gap_q, long_q);
    hit[bmcd_pkg::GST_RIGHT_DOUBLE] = click_ok(ring_time_d[bmcd_pkg::BTN_RIGHT],
      ring_dur_d[bmcd_pkg::BTN_RIGHT], ring_cnt_d[bmcd_pkg::BTN_RIGHT], 2,
      latch_q[bmcd_pkg::GST_RIGHT_DOUBLE], s1_time_q, gap_q, long_q);
  end

  // Latch the newest press time of every reported gesture; toggle save on chest double
  always_comb begin
    latch_d = latch_q;
    for (int g = 0; g < NGST; g++) begin
      if (hit[g]) begin
        latch_d[g] = ring_time_d[bmcd_pkg::gst_button(g)][0];
      end
    end
    save_d = save_q ^ hit[bmcd_pkg::GST_CHEST_DOUBLE];
  end

  // Advance ring contents
  always_ff @(posedge clk_i) begin
    if (fire) begin
      ring_time_q <= ring_time_d;
      ring_dur_q  <= ring_dur_d;
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NBTN; b++) begin
        ring_cnt_q[b] <= '0;
      end
      for (int g = 0; g < NGST; g++) begin
        latch_q[g] <= '0;
      end
      prior_q <= '0;
      save_q  <= 1'b0;
    end else if (fire) begin
      ring_cnt_q <= ring_cnt_d;
      latch_q    <= latch_d;
      prior_q    <= s1_lvl_q;
      save_q     <= save_d;
    end
  end

  // Result register valid and save flag copy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      save_out_q  <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
      save_out_q  <= save_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold gesture flags until the next result loads
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= hit;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chest_long_o   = res_q[bmcd_pkg::GST_CHEST_LONG];
  assign chest_single_o = res_q[bmcd_pkg::GST_CHEST_SINGLE];
  assign chest_double_o = res_q[bmcd_pkg::GST_CHEST_DOUBLE];
  assign chest_triple_o = res_q[bmcd_pkg::GST_CHEST_TRIPLE];
  assign chest_quad_o   = res_q[bmcd_pkg::GST_CHEST_QUAD];
  assign left_long_o    = res_q[bmcd_pkg::GST_LEFT_LONG];
  assign left_single_o  = res_q[bmcd_pkg::GST_LEFT_SINGLE];
  assign left_double_o  = res_q[bmcd_pkg::GST_LEFT_DOUBLE];
  assign right_long_o   = res_q[bmcd_pkg::GST_RIGHT_LONG];
  assign right_single_o = res_q[bmcd_pkg::GST_RIGHT_SINGLE];
  assign right_double_o = res_q[bmcd_pkg::GST_RIGHT_DOUBLE];
  assign save_images_o  = save_out_q;

endmodule

>>> src/bmcd_checker.sv
// Port-level checker of the button gesture detector and its bind
`include "button_multi_click_detector_macros.svh"

module bmcd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic chest_long_o,
  input logic chest_single_o,
  input logic chest_double_o,
  input logic chest_triple_o,
  input logic chest_quad_o,
  input logic left_long_o,
  input logic left_single_o,
  input logic left_double_o,
  input logic right_long_o,
  input logic right_single_o,
  input logic right_double_o,
  input logic save_images_o
);

  logic [11:0] res_bus;

  assign res_bus = {chest_long_o, chest_single_o, chest_double_o, chest_triple_o,
                    chest_quad_o, left_long_o, left_single_o, left_double_o,
                    right_long_o, right_single_o, right_double_o, save_images_o};

  // A stalled result keeps its flags
  `BMCD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_bus),
    "result changed while stalled")

  // Input stalls only when a result is waiting
  `BMCD_NEVER(a_ready_low, !in_ready_o && !out_valid_o,
    "input stalled with empty result register")

  // The save flag flips only together with a double chest click
  `BMCD_ASSERT(a_save_toggle, !$stable(save_images_o) |-> chest_double_o && out_valid_o,
    "save flag changed without double chest click")

endmodule

bind button_multi_click_detector bmcd_checker u_bmcd_checker (.*);

>>> tb/button_multi_click_detector_tb.sv
// Self-checking testbench of the multi-click button gesture detector
module button_multi_click_detector_tb;
  import bmcd_pkg::*;

  localparam int RING       = RING_DEPTH_DEF;
  localparam int SAVE_BIT   = NGST;
  localparam int NPHASE     = 6;
  localparam int PHASE_TICKS = 170;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [NGST:0] flags_t;

  typedef struct packed {
    time_t                 time_ms;
    logic [NBTN-1:0]       level;
    logic                  dur_ok;
    logic [NBTN-1:0][15:0] dur;
  } tick_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Block ports
  logic       cfg_valid = 1'b0;
  logic [0:0] cfg_index = CFG_GAP_MS;
  gap_t       cfg_data  = '0;
  wire        cfg_ready_o;
  logic       in_valid  = 1'b0;
  wire        in_ready_o;
  tick_t      cur_tick  = '0;
  wire        out_valid_o;
  logic       out_ready = 1'b0;
  wire [NGST:0] dut_flags;

  button_multi_click_detector i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .time_ms_i        (cur_tick.time_ms),
    .chest_level_i    (cur_tick.level[BTN_CHEST]),
    .left_level_i     (cur_tick.level[BTN_LEFT]),
    .right_level_i    (cur_tick.level[BTN_RIGHT]),
    .durations_valid_i(cur_tick.dur_ok),
    .chest_duration_i (cur_tick.dur[BTN_CHEST]),
    .left_duration_i  (cur_tick.dur[BTN_LEFT]),
    .right_duration_i (cur_tick.dur[BTN_RIGHT]),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .chest_long_o     (dut_flags[GST_CHEST_LONG]),
    .chest_single_o   (dut_flags[GST_CHEST_SINGLE]),
    .chest_double_o   (dut_flags[GST_CHEST_DOUBLE]),
    .chest_triple_o   (dut_flags[GST_CHEST_TRIPLE]),
    .chest_quad_o     (dut_flags[GST_CHEST_QUAD]),
    .left_long_o      (dut_flags[GST_LEFT_LONG]),
    .left_single_o    (dut_flags[GST_LEFT_SINGLE]),
    .left_double_o    (dut_flags[GST_LEFT_DOUBLE]),
    .right_long_o     (dut_flags[GST_RIGHT_LONG]),
    .right_single_o   (dut_flags[GST_RIGHT_SINGLE]),
    .right_double_o   (dut_flags[GST_RIGHT_DOUBLE]),
    .save_images_o    (dut_flags[SAVE_BIT])
  );

  string flag_name [NGST+1] = '{
    "chest_long", "chest_single", "chest_double", "chest_triple", "chest_quad",
    "left_long", "left_single", "left_double",
    "right_long", "right_single", "right_double", "save_images"
  };

  // Pending ticks, expected gesture flags, run status
  tick_t       tick_q [$];
  flags_t      gesture_q [$];
  int unsigned err_cnt        = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_start     = 1'b0;
  int unsigned hold_left      = 0;
  time_t       clock_ms       = '0;

  // Gesture state mirror
  time_t ring_time [NBTN][RING];
  dur_t  ring_dur [NBTN][RING];
  int    ring_cnt [NBTN];
  logic  prev_lvl [NBTN];
  time_t latch_time [NGST];
  logic  save_on;
  gap_t  gap_cfg;
  dur_t  long_cfg;

  // Append a press to a button's history, dropping the oldest when full
  function automatic void log_press(int b, time_t t, dur_t d);
    if (ring_cnt[b] == RING) begin
      for (int k = 0; k + 1 < RING; k++) begin
        ring_time[b][k] = ring_time[b][k+1];
        ring_dur[b][k]  = ring_dur[b][k+1];
      end
      ring_cnt[b] = RING - 1;
    end
    ring_time[b][ring_cnt[b]] = t;
    ring_dur[b][ring_cnt[b]]  = d;
    ring_cnt[b]++;
  endfunction

  function automatic logic long_click(int b, int g);
    int    c;
    time_t newest;
    c = ring_cnt[b];
    if (c == 0) return 1'b0;
    newest = ring_time[b][c-1];
    if (latch_time[g] == newest || ring_dur[b][c-1] <= long_cfg) return 1'b0;
    latch_time[g] = newest;
    return 1'b1;
  endfunction

  function automatic logic n_click(int b, int n, int g, time_t now);
    int    c;
    time_t newest;
    time_t gap32;
    c     = ring_cnt[b];
    gap32 = time_t'(gap_cfg);
    if (c < n) return 1'b0;
    newest = ring_time[b][c-1];
    if (latch_time[g] == newest) return 1'b0;
    if (time_t'(now - newest) < gap32) return 1'b0;
    // presses inside the group must be close and short
    for (int i = c - 1; i > c - n; i--) begin
      if (time_t'(ring_time[b][i] - ring_time[b][i-1]) > gap32 ||
          ring_dur[b][i] > long_cfg) return 1'b0;
    end
    // an older press must sit far enough before the group
    if (c > n) begin
      if (time_t'(ring_time[b][c-n] - ring_time[b][c-n-1]) < gap32 ||
          ring_dur[b][c-n] > long_cfg) return 1'b0;
    end
    latch_time[g] = newest;
    return 1'b1;
  endfunction

  // Advance the mirror by one tick and return the flags it reports
  function automatic flags_t step_gestures(tick_t tk);
    flags_t f;
    f = '0;
    for (int b = 0; b < NBTN; b++) begin
      if (tk.dur_ok && prev_lvl[b] && !tk.level[b]) log_press(b, tk.time_ms, tk.dur[b]);
      prev_lvl[b] = tk.level[b];
    end
    f[GST_CHEST_LONG]   = long_click(BTN_CHEST, GST_CHEST_LONG);
    f[GST_CHEST_SINGLE] = n_click(BTN_CHEST, 1, GST_CHEST_SINGLE, tk.time_ms);
    f[GST_CHEST_DOUBLE] = n_click(BTN_CHEST, 2, GST_CHEST_DOUBLE, tk.time_ms);
    f[GST_CHEST_TRIPLE] = n_click(BTN_CHEST, 3, GST_CHEST_TRIPLE, tk.time_ms);
    f[GST_CHEST_QUAD]   = n_click(BTN_CHEST, 4, GST_CHEST_QUAD, tk.time_ms);
    f[GST_LEFT_LONG]    = long_click(BTN_LEFT, GST_LEFT_LONG);
    f[GST_LEFT_SINGLE]  = n_click(BTN_LEFT, 1, GST_LEFT_SINGLE, tk.time_ms);
    f[GST_LEFT_DOUBLE]  = n_click(BTN_LEFT, 2, GST_LEFT_DOUBLE, tk.time_ms);
    f[GST_RIGHT_LONG]   = long_click(BTN_RIGHT, GST_RIGHT_LONG);
    f[GST_RIGHT_SINGLE] = n_click(BTN_RIGHT, 1, GST_RIGHT_SINGLE, tk.time_ms);
    f[GST_RIGHT_DOUBLE] = n_click(BTN_RIGHT, 2, GST_RIGHT_DOUBLE, tk.time_ms);
    if (f[GST_CHEST_DOUBLE]) save_on = ~save_on;
    f[SAVE_BIT] = save_on;
    return f;
  endfunction

  // Queue one tick dt ms after the previous one, with random durations
  function automatic void push_tick(time_t dt, logic [NBTN-1:0] lvl, logic dv);
    tick_t tk;
    clock_ms   = clock_ms + dt;
    tk.time_ms = clock_ms;
    tk.level   = lvl;
    tk.dur_ok  = dv;
    for (int b = 0; b < NBTN; b++) tk.dur[b] = dur_t'($urandom_range(16'hFFFF, 0));
    tick_q = {tick_q, tk};
  endfunction

  // Queue a press whose release lands interval ms after the previous tick
  function automatic void add_press(int b, time_t interval, dur_t d);
    time_t           hold;
    logic [NBTN-1:0] lvl;
    hold   = $urandom_range((interval < 20) ? interval : 20, 0);
    lvl    = '0;
    lvl[b] = 1'b1;
    push_tick(interval - hold, lvl, 1'($urandom_range(1, 0)));
    push_tick(hold, '0, $urandom_range(19, 0) != 0);
    tick_q[$].dur[b] = d;
  endfunction

  // Pick a spacing near the gap: mostly beyond it for group borders, inside it otherwise
  function automatic time_t pick_gap(bit beyond);
    time_t       g;
    int unsigned sel;
    g   = time_t'(gap_cfg);
    sel = $urandom_range(99, 0);
    if (sel < 15) return g;
    if (sel < 30) return beyond ? ((g == 0) ? g : g - 1) : g + 1;
    if (sel < 45) return $urandom_range(2 * g + 1, 0);
    return beyond ? g + $urandom_range(300, 1) : time_t'($urandom_range(g, 0));
  endfunction

  function automatic dur_t pick_dur();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 10) return long_cfg;
    if (sel < 20) return (long_cfg == 16'hFFFF) ? long_cfg : long_cfg + 16'd1;
    if (sel < 30) return dur_t'($urandom_range(16'hFFFF, 0));
    return dur_t'($urandom_range(long_cfg, 0));
  endfunction

  // Queue random click groups, long presses and noise
  function automatic void add_random_ticks(int unsigned count);
    int unsigned target;
    int unsigned sel;
    int          b;
    int          n;
    target = tick_q.size() + count;
    while (tick_q.size() < target) begin
      sel = $urandom_range(99, 0);
      b   = $urandom_range(NBTN - 1, 0);
      if (sel < 60) begin
        n = (b == BTN_CHEST) ? $urandom_range(5, 1) : $urandom_range(3, 1);
        add_press(b, pick_gap(1'b1), pick_dur());
        for (int k = 1; k < n; k++) add_press(b, pick_gap(1'b0), pick_dur());
        push_tick(pick_gap(1'b1), '0, 1'($urandom_range(1, 0)));
        if ($urandom_range(1, 0)) push_tick(pick_gap(1'b1), '0, 1'($urandom_range(1, 0)));
      end else if (sel < 75) begin
        add_press(b, pick_gap(1'b1),
                  (long_cfg == 16'hFFFF) ? long_cfg
                                         : dur_t'($urandom_range(16'hFFFF, long_cfg + 1)));
        push_tick(pick_gap(1'b1), '0, 1'($urandom_range(1, 0)));
      end else begin
        n = $urandom_range(4, 1);
        for (int k = 0; k < n; k++) begin
          push_tick(($urandom_range(3, 0) == 0) ? time_t'($urandom)
                                                : time_t'($urandom_range(2 * gap_cfg + 1, 0)),
                    NBTN'($urandom_range(7, 0)), 1'($urandom_range(1, 0)));
        end
      end
    end
  endfunction

  task automatic write_reg(cfg_idx_e idx, gap_t val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CFG_GAP_MS) gap_cfg = val;
    else long_cfg = val;
  endtask

  // Driver: offer the next tick whenever the input slot is free
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) gesture_q = {gesture_q, step_gestures(cur_tick)};
      if (!in_valid || in_ready_o) begin
        if (tick_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          cur_tick <= tick_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    flags_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (gesture_q.size() == 0) begin
          err_cnt++;
          if (err_cnt < 50) $display("%0t: result %b with no tick pending", $time, dut_flags);
        end else begin
          want = gesture_q.pop_front();
          for (int f = 0; f <= NGST; f++) begin
            if (dut_flags[f] !== want[f]) begin
              err_cnt++;
              if (err_cnt < 50) begin
                $display("%0t: %s expected %0b, actual %0b", $time, flag_name[f], want[f],
                         dut_flags[f]);
              end
            end
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus: directed ticks, then random phases over several settings
  initial begin
    int unsigned ph_gap [NPHASE];
    int unsigned ph_long [NPHASE];
    int unsigned ph_send [NPHASE];
    int unsigned ph_recv [NPHASE];
    ph_gap  = '{500, 0, 65535, 300, 0, 500};
    ph_long = '{800, 0, 65535, 400, 0, 800};
    ph_send = '{0, 46, 0, 37, 0, 37};
    ph_recv = '{0, 0, 46, 37, 46, 37};
    for (int b = 0; b < NBTN; b++) begin
      ring_cnt[b] = 0;
      prev_lvl[b] = 1'b0;
      for (int k = 0; k < RING; k++) begin
        ring_time[b][k] = '0;
        ring_dur[b][k]  = '0;
      end
    end
    for (int g = 0; g < NGST; g++) latch_time[g] = '0;
    save_on  = 1'b0;
    gap_cfg  = GAP_MS_RST;
    long_cfg = LONG_MS_RST;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NPHASE; p++) begin
      if (p != 0) begin
        if (p == 4) begin
          ph_gap[p]  = $urandom_range(3000, 1);
          ph_long[p] = $urandom_range(16'hFFFF, 0);
        end
        write_reg(CFG_GAP_MS, gap_t'(ph_gap[p]));
        write_reg(CFG_LONG_MS, gap_t'(ph_long[p]));
      end
      @(posedge clk_i);
      send_idle_pct  <= ph_send[p];
      recv_stall_pct <= ph_recv[p];
      if (p == 0) begin
        // press released at time zero matches the cleared latch
        push_tick(0, 3'b001, 1'b1);
        push_tick(0, 3'b000, 1'b1);
        tick_q[$].dur[BTN_CHEST] = 16'd100;
        push_tick(600, '0, 1'b0);
        // left edge without durations is dropped
        push_tick(100, 3'b010, 1'b1);
        push_tick(10, 3'b000, 1'b0);
        // longest chest press, right press exactly at the long limit
        add_press(BTN_CHEST, 290, 16'hFFFF);
        add_press(BTN_RIGHT, 1000, LONG_MS_RST);
        push_tick(time_t'(GAP_MS_RST), '0, 1'b1);
        // left pair at exactly the gap, second press just too long
        add_press(BTN_LEFT, 1000, 16'd0);
        add_press(BTN_LEFT, time_t'(GAP_MS_RST), LONG_MS_RST + 16'd1);
        push_tick(time_t'(GAP_MS_RST), '0, 1'b1);
        // chest quad, then a chest double that flips the save flag
        add_press(BTN_CHEST, 1000, 16'd10);
        for (int k = 0; k < 3; k++) add_press(BTN_CHEST, 200, 16'd20);
        add_press(BTN_CHEST, 1000, 16'd5);
        add_press(BTN_CHEST, 100, 16'd6);
        push_tick(time_t'(GAP_MS_RST), '0, 1'b1);
      end
      add_random_ticks(PHASE_TICKS);
      if (p == 2) begin
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end
      // hold off the next setting until every result is back
      while (tick_q.size() != 0 || in_valid || gesture_q.size() != 0) @(posedge clk_i);
      repeat (3) @(posedge clk_i);
    end

    repeat (8) @(posedge clk_i);
    if (gesture_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $time, gesture_q.size());
    end
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
